[rtl/u8d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants for the UTF-8 stream decoder
// Byte classes, the queue entry that travels from front to back, and the
// masks that pick the payload bits out of lead and continuation bytes.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // Width of a decoded code point.
  localparam int unsigned CpWidth    = 21;
  // Width of the sequence length field.
  localparam int unsigned UnitsWidth = 3;
  // Payload bits kept from one byte (at most seven, for a single-byte code).
  localparam int unsigned BitsWidth  = 7;
  // Payload bits carried by one continuation byte.
  localparam int unsigned ContBits   = 6;

  // Payload masks for each byte class.
  localparam logic [BitsWidth-1:0] MaskAscii = 7'h7F;
  localparam logic [BitsWidth-1:0] MaskCont  = 7'h3F;
  localparam logic [BitsWidth-1:0] MaskLead2 = 7'h1F;
  localparam logic [BitsWidth-1:0] MaskLead3 = 7'h0F;
  localparam logic [BitsWidth-1:0] MaskLead4 = 7'h07;

  // Sequence lengths in bytes.
  localparam logic [UnitsWidth-1:0] LenOne   = 3'd1;
  localparam logic [UnitsWidth-1:0] LenTwo   = 3'd2;
  localparam logic [UnitsWidth-1:0] LenThree = 3'd3;
  localparam logic [UnitsWidth-1:0] LenFour  = 3'd4;
  localparam logic [UnitsWidth-1:0] LenNone  = 3'd0;

  // Continuation bytes still expected after a lead byte.
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendOne   = 2'd1;
  localparam logic [1:0] PendTwo   = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  // Class of one input byte, decided from its high bits.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_cls_e;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    byte_cls_e            cls;
    logic [BitsWidth-1:0] bits;
    logic                 last;
  } item_t;

endpackage

[rtl/utf8_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming UTF-8 decoder, one byte per clock while not stalled
// Turns a byte stream into code points with their byte counts, flags
// malformed and truncated sequences, and reports per-text validity.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o  data_byte_i, end_of_text_i
//   output    out        out_valid_o/out_stall_i code_point_o, units_used_o,
//                                               error_o, text_done_o,
//                                               text_valid_o
//
// One byte is accepted per clock while the input is not stalled; its result,
// if any, enters the queue at the accepting edge and the output register when
// the back end pops it. The byte rate is set by the sequence update in the
// back end. Reset returns the decoder to neutral with an empty queue and no
// result. An output stall holds the result; the queue absorbs QueueDepth bytes
// before the input is stalled.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              end_of_text_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [u8d_pkg::CpWidth-1:0]       code_point_o,
  output logic [u8d_pkg::UnitsWidth-1:0]    units_used_o,
  output logic                              error_o,
  output logic                              text_done_o,
  output logic                              text_valid_o
);

  logic            q_full;
  logic            q_not_empty;
  logic            push;
  logic            pop;
  u8d_pkg::item_t  push_item;
  u8d_pkg::item_t  pop_item;

  // Intake and classification.
  u8d_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Queue between front and back.
  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .pop_i       (pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .item_o      (pop_item)
  );

  // Sequence decoding and result register.
  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .not_empty_i  (q_not_empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .units_used_o (units_used_o),
    .error_o      (error_o),
    .text_done_o  (text_done_o),
    .text_valid_o (text_valid_o)
  );

endmodule

[rtl/u8d_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_front: byte intake and classification
// Accepts raw bytes, sorts each one into a byte class, strips the marker
// bits and pushes the result into the queue toward the decoding back end.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_text_i,
  input  logic            q_full_i,
  output logic            push_o,
  output u8d_pkg::item_t  item_o
);

  u8d_pkg::byte_cls_e              cls;
  logic [u8d_pkg::BitsWidth-1:0]   mask;

  // Classify the byte by its leading one bits.
  always_comb begin
    case (data_byte_i) inside
      [8'h00:8'h7F]: begin
        cls  = u8d_pkg::CLS_ASCII;
        mask = u8d_pkg::MaskAscii;
      end
      [8'h80:8'hBF]: begin
        cls  = u8d_pkg::CLS_CONT;
        mask = u8d_pkg::MaskCont;
      end
      [8'hC0:8'hDF]: begin
        cls  = u8d_pkg::CLS_LEAD2;
        mask = u8d_pkg::MaskLead2;
      end
      [8'hE0:8'hEF]: begin
        cls  = u8d_pkg::CLS_LEAD3;
        mask = u8d_pkg::MaskLead3;
      end
      [8'hF0:8'hF7]: begin
        cls  = u8d_pkg::CLS_LEAD4;
        mask = u8d_pkg::MaskLead4;
      end
      default: begin
        cls  = u8d_pkg::CLS_BAD;
        mask = '0;
      end
    endcase
  end

  // Hold off the sender while the queue has no room.
  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign item_o.cls  = cls;
  assign item_o.bits = data_byte_i[u8d_pkg::BitsWidth-1:0] & mask;
  assign item_o.last = end_of_text_i;

endmodule

[rtl/u8d_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_queue: short queue between front and back
// A small circular buffer of classified bytes, so that the front keeps
// taking bytes while the back waits on a stalled output.
// ----------------------------------------------------------------------------
module u8d_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8d_pkg::item_t  item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            not_empty_o,
  output u8d_pkg::item_t  item_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(Depth);

  u8d_pkg::item_t        mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;

  assign full_o      = (count_q == FullCnt);
  assign not_empty_o = (count_q != '0);
  assign item_o      = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/u8d_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_back: sequence decoding and result register
// Pops classified bytes, tracks the open sequence and the error flag of the
// current text, and loads finished results into the output register.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              not_empty_i,
  input  u8d_pkg::item_t                    item_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [u8d_pkg::CpWidth-1:0]       code_point_o,
  output logic [u8d_pkg::UnitsWidth-1:0]    units_used_o,
  output logic                              error_o,
  output logic                              text_done_o,
  output logic                              text_valid_o
);

  localparam int unsigned KeepBits = u8d_pkg::CpWidth - u8d_pkg::ContBits;

  // Decoder state.
  logic [1:0]                       pend_q, pend_d;
  logic [u8d_pkg::CpWidth-1:0]      acc_q, acc_d;
  logic [u8d_pkg::UnitsWidth-1:0]   len_q, len_d;
  logic                             had_err_q, had_err_d;

  // Output register.
  logic                             out_valid_q, out_valid_d;
  logic [u8d_pkg::CpWidth-1:0]      cp_q, cp_d;
  logic [u8d_pkg::UnitsWidth-1:0]   units_q, units_d;
  logic                             err_q, err_d;
  logic                             done_q, done_d;
  logic                             tvalid_q, tvalid_d;

  // Per-byte decode results.
  logic                             emit, err;
  logic [u8d_pkg::CpWidth-1:0]      cp;
  logic [u8d_pkg::UnitsWidth-1:0]   units;
  logic [1:0]                       pend_n;
  logic [u8d_pkg::CpWidth-1:0]      acc_n;
  logic [u8d_pkg::UnitsWidth-1:0]   len_n;
  logic                             had_err_n;

  // Take a byte whenever the output register is free or is being drained.
  assign pop_o = not_empty_i && (!out_valid_q || !out_stall_i);

  // Decode one byte against the open sequence.
  always_comb begin
    emit   = 1'b0;
    err    = 1'b0;
    cp     = '0;
    units  = u8d_pkg::LenNone;
    pend_n = pend_q;
    acc_n  = acc_q;
    len_n  = len_q;
    if (pend_q == u8d_pkg::PendNone) begin
      case (item_i.cls)
        u8d_pkg::CLS_ASCII: begin
          emit  = 1'b1;
          cp    = u8d_pkg::CpWidth'(item_i.bits);
          units = u8d_pkg::LenOne;
        end
        u8d_pkg::CLS_LEAD2: begin
          acc_n  = u8d_pkg::CpWidth'(item_i.bits);
          pend_n = u8d_pkg::PendOne;
          len_n  = u8d_pkg::LenTwo;
        end
        u8d_pkg::CLS_LEAD3: begin
          acc_n  = u8d_pkg::CpWidth'(item_i.bits);
          pend_n = u8d_pkg::PendTwo;
          len_n  = u8d_pkg::LenThree;
        end
        u8d_pkg::CLS_LEAD4: begin
          acc_n  = u8d_pkg::CpWidth'(item_i.bits);
          pend_n = u8d_pkg::PendThree;
          len_n  = u8d_pkg::LenFour;
        end
        default: begin
          // Stray continuation byte or invalid lead byte.
          err = 1'b1;
        end
      endcase
    end else if (item_i.cls != u8d_pkg::CLS_CONT) begin
      // Missing continuation byte: this byte is consumed by the error.
      err = 1'b1;
    end else begin
      acc_n  = {acc_q[KeepBits-1:0], item_i.bits[u8d_pkg::ContBits-1:0]};
      pend_n = pend_q - 1'b1;
      if (pend_n == u8d_pkg::PendNone) begin
        emit  = 1'b1;
        cp    = acc_n;
        units = len_q;
      end
    end

    // A text that ends inside a sequence is an error.
    if (item_i.last && !err && (pend_n != u8d_pkg::PendNone)) begin
      err = 1'b1;
    end

    had_err_n = had_err_q;
    if (err) begin
      emit      = 1'b1;
      cp        = '0;
      units     = u8d_pkg::LenNone;
      had_err_n = 1'b1;
    end
    if (err || emit) begin
      pend_n = u8d_pkg::PendNone;
      acc_n  = '0;
      len_n  = u8d_pkg::LenNone;
    end
    if (item_i.last) begin
      emit = 1'b1;
    end
  end

  // Next state and output register contents.
  always_comb begin
    pend_d      = pend_q;
    acc_d       = acc_q;
    len_d       = len_q;
    had_err_d   = had_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    cp_d        = cp_q;
    units_d     = units_q;
    err_d       = err_q;
    done_d      = done_q;
    tvalid_d    = tvalid_q;
    if (pop_o) begin
      pend_d    = pend_n;
      acc_d     = acc_n;
      len_d     = len_n;
      had_err_d = had_err_n;
      if (item_i.last) begin
        // The final byte starts the next text from neutral.
        pend_d    = u8d_pkg::PendNone;
        acc_d     = '0;
        len_d     = u8d_pkg::LenNone;
        had_err_d = 1'b0;
      end
      if (emit) begin
        out_valid_d = 1'b1;
        cp_d        = cp;
        units_d     = units;
        err_d       = err;
        done_d      = item_i.last;
        tvalid_d    = item_i.last && !had_err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= u8d_pkg::PendNone;
      acc_q       <= '0;
      len_q       <= u8d_pkg::LenNone;
      had_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      had_err_q   <= had_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q     <= cp_d;
    units_q  <= units_d;
    err_q    <= err_d;
    done_q   <= done_d;
    tvalid_q <= tvalid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign units_used_o = units_q;
  assign error_o      = err_q;
  assign text_done_o  = done_q;
  assign text_valid_o = tvalid_q;

  // An error result carries no code point and no length.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> (cp_q == '0) && (units_q == u8d_pkg::LenNone))
    else $error("error result carries a code point or length");

  // A good result always has a length of one to four bytes.
  a_units_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !err_q && !done_q |-> (units_q != u8d_pkg::LenNone))
    else $error("good result without a length");

  // Text validity is only reported on the final result.
  a_tvalid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tvalid_q |-> done_q)
    else $error("text_valid set without text_done");

  // The final byte of a text leaves the decoder neutral and error free.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> (pend_q == u8d_pkg::PendNone) && !had_err_q
      && (acc_q == '0))
    else $error("state not cleared after end of text");

endmodule
